// ----- sv/vpp_pkg.sv -----
`default_nettype none
package vpp_pkg;

  // Screen size in pixels
  localparam int SCREEN_WIDTH  = 1280;
  localparam int SCREEN_HEIGHT = 720;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_X     = 3'd0,
    REG_CAM_Y     = 3'd1,
    REG_CAM_Z     = 3'd2,
    REG_COS_YAW   = 3'd3,
    REG_SIN_YAW   = 3'd4,
    REG_COS_PITCH = 3'd5,
    REG_SIN_PITCH = 3'd6
  } cfg_reg_t;

  // World scaling: round(v * 8192 / 25) = floor((16384 v + 25) / 50),
  // done as a reciprocal multiply on a value biased to be positive.
  localparam logic [31:0] SCALE_OFS   = 32'd838860825;  // 50 * 2^24 + 25
  localparam logic [31:0] SCALE_RECIP = 32'd2748779070; // ceil(2^37 / 50)
  localparam logic [25:0] SCALE_BIAS  = 26'd16777216;   // 2^24

  localparam int OFS_W = 33;  // camera-relative offset, Q16.16
  localparam int ROT_W = 36;  // rotated coordinate, Q16.16

  // Divider geometry
  localparam int DIV_NUM_W = 62;
  localparam int DIV_DEN_W = 35;
  localparam int DIV_Q_W   = 40;
  localparam int DIV_LAT   = DIV_Q_W + 1;
  localparam int DIV_RES_W = DIV_Q_W + 1;

  localparam logic [DIV_NUM_W-1:0] SIZE_NUM = 62'd42949672960; // 10 * 2^32

  localparam int POS_W = 42;
  localparam logic signed [POS_W-1:0] CX_Q = POS_W'((SCREEN_WIDTH / 2) * 65536);
  localparam logic signed [POS_W-1:0] CY_Q = POS_W'((SCREEN_HEIGHT / 2) * 65536);
  localparam logic signed [POS_W:0]   WQ   = (POS_W+1)'(SCREEN_WIDTH * 65536);
  localparam logic signed [POS_W:0]   HQ   = (POS_W+1)'(SCREEN_HEIGHT * 65536);

endpackage
`default_nettype wire

// ----- sv/voxel_perspective_projector.sv -----
`default_nettype none
// Voxel perspective projector.
// Input channel (in_valid / in_stall): one voxel per item, grid coordinates
// in_voxel_x/y/z and a 24-bit colour. Result channel (out_valid /
// out_stall): one square per visible voxel, four pixel edges saturated to
// 16 bits plus the colour. Voxels behind the camera or off screen give no
// result and leave no trace in the result stream.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
// camera position and yaw/pitch sine and cosine. cfg_ready is always high;
// write only while no voxel is in flight. Unknown indexes are ignored.
// Throughput: one voxel per cycle while the output is not stalled. The path
// runs through 50 register stages: the 41-stage divider (a setup stage, then
// a quotient bit per stage; three lanes: x, y and size) plus seven front
// stages (scale, offset, yaw, pitch, focal) and two back stages (centre,
// edges).
// Reset: the pipeline empties, camera at the origin, no rotation.
// Stall: while a result waits with out_stall high the whole pipeline holds
// and in_stall rises; nothing is dropped or repeated. Bubbles keep their
// slots.
module voxel_perspective_projector (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [15:0]                in_voxel_x,
  input  wire logic signed [15:0]                in_voxel_y,
  input  wire logic signed [15:0]                in_voxel_z,
  input  wire logic        [23:0]                in_color,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [15:0]                     out_left_x,
  output logic signed [15:0]                     out_right_x,
  output logic signed [15:0]                     out_top_y,
  output logic signed [15:0]                     out_bottom_y,
  output logic        [23:0]                     out_quad_color,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [vpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                       cfg_data
);

  localparam int OW  = vpp_pkg::OFS_W;
  localparam int RW  = vpp_pkg::ROT_W;
  localparam int DL  = vpp_pkg::DIV_LAT;
  localparam int QRW = vpp_pkg::DIV_RES_W;
  localparam int PW  = vpp_pkg::POS_W;

  // Round a Q16.16 value to the nearest pixel, ties up, and saturate
  function automatic logic [15:0] to_pixel(input logic signed [PW+1:0] q);
    logic signed [PW+1:0] r;
    r = (q + (PW+2)'(32768)) >>> 16;
    if (r > (PW+2)'(32767))
      return 16'h7fff;
    else if (r < -(PW+2)'(32768))
      return 16'h8000;
    else
      return r[15:0];
  endfunction

  // ---------------- configuration registers ----------------
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic signed [15:0] cos_yaw_r, sin_yaw_r, cos_pitch_r, sin_pitch_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r     <= '0;
      cam_y_r     <= '0;
      cam_z_r     <= '0;
      cos_yaw_r   <= 16'sd16384;
      sin_yaw_r   <= '0;
      cos_pitch_r <= 16'sd16384;
      sin_pitch_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (vpp_pkg::cfg_reg_t'(cfg_index))
        vpp_pkg::REG_CAM_X:     cam_x_r     <= cfg_data;
        vpp_pkg::REG_CAM_Y:     cam_y_r     <= cfg_data;
        vpp_pkg::REG_CAM_Z:     cam_z_r     <= cfg_data;
        vpp_pkg::REG_COS_YAW:   cos_yaw_r   <= cfg_data[15:0];
        vpp_pkg::REG_SIN_YAW:   sin_yaw_r   <= cfg_data[15:0];
        vpp_pkg::REG_COS_PITCH: cos_pitch_r <= cfg_data[15:0];
        vpp_pkg::REG_SIN_PITCH: sin_pitch_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- global advance ----------------
  logic en;
  logic out_vld_r;
  assign en       = !out_vld_r || !out_stall;
  assign in_stall = !en;

  // ---------------- stage 1: world scaling multiply ----------------
  logic [62:0] s1_prod_r [3];
  logic        s1_vld_r;
  logic [23:0] s1_col_r;
  logic [30:0] s1_n [3];

  always_comb begin
    logic signed [15:0] v [3];
    logic        [31:0] t;
    v[0] = in_voxel_x;
    v[1] = in_voxel_y;
    v[2] = in_voxel_z;
    for (int i = 0; i < 3; i++) begin
      t       = {{2{v[i][15]}}, v[i], 14'b0} + vpp_pkg::SCALE_OFS;
      s1_n[i] = t[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        s1_prod_r[i] <= 63'(s1_n[i]) * 63'(vpp_pkg::SCALE_RECIP);
      s1_col_r <= in_color;
    end
  end

  // ---------------- stage 2: camera offset ----------------
  logic signed [OW-1:0] s2_o_r [3];
  logic                 s2_vld_r;
  logic [23:0]          s2_col_r;
  logic signed [OW-1:0] s2_o_nxt [3];

  always_comb begin
    logic [25:0] w;
    logic [31:0] cam [3];
    cam[0] = cam_x_r;
    cam[1] = cam_y_r;
    cam[2] = cam_z_r;
    for (int i = 0; i < 3; i++) begin
      w           = s1_prod_r[i][62:37] - vpp_pkg::SCALE_BIAS;
      s2_o_nxt[i] = {{(OW-26){w[25]}}, w} - {cam[i][31], cam[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        s2_o_r[i] <= s2_o_nxt[i];
      s2_col_r <= s1_col_r;
    end
  end

  // ---------------- stage 3: yaw products ----------------
  logic signed [48:0]   s3_xc_r, s3_zs_r, s3_xs_r, s3_zc_r;
  logic signed [OW-1:0] s3_y_r;
  logic                 s3_vld_r;
  logic [23:0]          s3_col_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_xc_r  <= 49'(s2_o_r[0]) * 49'(cos_yaw_r);
      s3_zs_r  <= 49'(s2_o_r[2]) * 49'(sin_yaw_r);
      s3_xs_r  <= 49'(s2_o_r[0]) * 49'(sin_yaw_r);
      s3_zc_r  <= 49'(s2_o_r[2]) * 49'(cos_yaw_r);
      s3_y_r   <= s2_o_r[1];
      s3_col_r <= s2_col_r;
    end
  end

  // ---------------- stage 4: yaw sums ----------------
  logic signed [RW-1:0] s4_x_r, s4_z_r;
  logic signed [OW-1:0] s4_y_r;
  logic                 s4_vld_r;
  logic [23:0]          s4_col_r;
  logic signed [49:0]   s4_sx, s4_sz;

  // Yaw sums stay well inside the rotation range, so no saturation here
  always_comb begin
    s4_sx = ((50'(s3_xc_r) - 50'(s3_zs_r)) + 50'sd8192) >>> 14;
    s4_sz = ((50'(s3_xs_r) + 50'(s3_zc_r)) + 50'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x_r   <= s4_sx[RW-1:0];
      s4_z_r   <= s4_sz[RW-1:0];
      s4_y_r   <= s3_y_r;
      s4_col_r <= s3_col_r;
    end
  end

  // ---------------- stage 5: pitch products ----------------
  logic signed [51:0]   s5_yc_r, s5_zs_r, s5_ys_r, s5_zc_r;
  logic signed [RW-1:0] s5_x_r;
  logic                 s5_vld_r;
  logic [23:0]          s5_col_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_yc_r  <= 52'(s4_y_r) * 52'(cos_pitch_r);
      s5_zs_r  <= 52'(s4_z_r) * 52'(sin_pitch_r);
      s5_ys_r  <= 52'(s4_y_r) * 52'(sin_pitch_r);
      s5_zc_r  <= 52'(s4_z_r) * 52'(cos_pitch_r);
      s5_x_r   <= s4_x_r;
      s5_col_r <= s4_col_r;
    end
  end

  // ---------------- stage 6: pitch sums, saturate ----------------
  logic signed [RW-1:0] s6_x_r, s6_y_r, s6_z_r;
  logic                 s6_vld_r;
  logic [23:0]          s6_col_r;
  logic signed [RW-1:0] s6_y_nxt, s6_z_nxt;

  function automatic logic signed [RW-1:0] sat_rot(input logic signed [52:0] v);
    if (v > 53'sd34359738367)
      return {1'b0, {(RW-1){1'b1}}};
    else if (v < -53'sd34359738368)
      return {1'b1, {(RW-1){1'b0}}};
    else
      return v[RW-1:0];
  endfunction

  always_comb begin
    s6_y_nxt = sat_rot(((53'(s5_yc_r) - 53'(s5_zs_r)) + 53'sd8192) >>> 14);
    s6_z_nxt = sat_rot(((53'(s5_ys_r) + 53'(s5_zc_r)) + 53'sd8192) >>> 14);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_x_r   <= s5_x_r;
      s6_y_r   <= s6_y_nxt;
      s6_z_r   <= s6_z_nxt;
      s6_col_r <= s5_col_r;
    end
  end

  // ---------------- stage 7: focal scaling, depth test ----------------
  logic signed [46:0] s7_fx, s7_fy;
  logic signed [45:0] s7_nx_r, s7_ny_r;
  logic [vpp_pkg::DIV_DEN_W-1:0] s7_z_r;
  logic               s7_vld_r;
  logic [23:0]        s7_col_r;
  logic               s6_zpos;

  always_comb begin
    s7_fx   = 47'(s6_x_r) * 47'sd1000;
    s7_fy   = 47'(s6_y_r) * 47'sd1000;
    s6_zpos = !s6_z_r[RW-1] && (s6_z_r != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_nx_r  <= s7_fx[45:0];
      s7_ny_r  <= s7_fy[45:0];
      s7_z_r   <= s6_z_r[vpp_pkg::DIV_DEN_W-1:0];
      s7_col_r <= s6_col_r;
    end
  end

  // Valid bits for the front stages; drop voxels at or behind the camera
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r && s6_zpos;
    end
  end

  // ---------------- dividers ----------------
  logic signed [QRW-1:0] qx, qy, qs;

  vpp_div u_div_x (
    .clk (clk),
    .en  (en),
    .num ({s7_nx_r, 16'b0}),
    .den (s7_z_r),
    .quo (qx)
  );

  vpp_div u_div_y (
    .clk (clk),
    .en  (en),
    .num ({s7_ny_r, 16'b0}),
    .den (s7_z_r),
    .quo (qy)
  );

  vpp_div u_div_s (
    .clk (clk),
    .en  (en),
    .num (vpp_pkg::SIZE_NUM),
    .den (s7_z_r),
    .quo (qs)
  );

  // Valid and colour ride alongside the divider
  logic [DL-1:0] dvld_r;
  logic [23:0]   dcol_r [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
    end else if (en) begin
      dvld_r <= {dvld_r[DL-2:0], s7_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dcol_r[0] <= s7_col_r;
      for (int k = 1; k < DL; k++)
        dcol_r[k] <= dcol_r[k-1];
    end
  end

  // ---------------- post stage 1: screen centre ----------------
  logic signed [PW-1:0]  p1_px_r, p1_py_r;
  logic signed [QRW-1:0] p1_size_r;
  logic                  p1_vld_r;
  logic [23:0]           p1_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= dvld_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_px_r   <= PW'(qx) + vpp_pkg::CX_Q;
      p1_py_r   <= PW'(qy) + vpp_pkg::CY_Q;
      p1_size_r <= qs;
      p1_col_r  <= dcol_r[DL-1];
    end
  end

  // ---------------- post stage 2: cull, edges ----------------
  logic signed [PW:0]   p2_px, p2_py, p2_nsize;
  logic signed [PW+1:0] p2_half;
  logic                 p2_show;
  logic signed [15:0]   out_l_r, out_r_r, out_t_r, out_b_r;
  logic [23:0]          out_col_r;

  always_comb begin
    p2_px    = (PW+1)'(p1_px_r);
    p2_py    = (PW+1)'(p1_py_r);
    p2_nsize = -(PW+1)'(p1_size_r);
    p2_half  = (PW+2)'(p1_size_r) >>> 1;
    p2_show  = !(p2_px < p2_nsize || p2_px > vpp_pkg::WQ ||
                 p2_py < p2_nsize || p2_py > vpp_pkg::HQ);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= p1_vld_r && p2_show;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_l_r   <= to_pixel((PW+2)'(p1_px_r) - p2_half);
      out_r_r   <= to_pixel((PW+2)'(p1_px_r) + p2_half);
      out_t_r   <= to_pixel((PW+2)'(p1_py_r) - p2_half);
      out_b_r   <= to_pixel((PW+2)'(p1_py_r) + p2_half);
      out_col_r <= p1_col_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_left_x     = out_l_r;
  assign out_right_x    = out_r_r;
  assign out_top_y      = out_t_r;
  assign out_bottom_y   = out_b_r;
  assign out_quad_color = out_col_r;

  // ---------------- assertions ----------------
  a_lr_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_l_r <= out_r_r)
    else $error("left edge beyond right edge");

  a_tb_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_t_r <= out_b_r)
    else $error("top edge below bottom edge");

  a_hold_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(dvld_r))
    else $error("divider valid line moved during stall");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |=> out_vld_r && $stable(out_col_r))
    else $error("stalled result lost");

endmodule
`default_nettype wire

// ----- sv/vpp_div.sv -----
`default_nettype none
// Pipelined floor division of a signed numerator by a positive divisor,
// one quotient bit per stage. Quotients beyond the range clamp.
module vpp_div (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire logic signed [vpp_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic        [vpp_pkg::DIV_DEN_W-1:0]  den,
  output logic signed      [vpp_pkg::DIV_RES_W-1:0]  quo
);

  localparam int QW = vpp_pkg::DIV_Q_W;
  localparam int DW = vpp_pkg::DIV_DEN_W;
  localparam int NW = vpp_pkg::DIV_NUM_W;

  logic [DW-1:0] rem_r [QW+1];
  logic [QW-1:0] sh_r  [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic          neg_r [QW+1];
  logic          ovf_r [QW+1];

  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] sh_nxt  [QW];

  logic [NW-2:0]    mag;
  logic [NW-QW-2:0] hi;
  logic             ovf;

  // Fold negative numerators onto ~a so floor(a/b) = ~floor(~a/b)
  always_comb begin
    mag = num[NW-1] ? ~num[NW-2:0] : num[NW-2:0];
    hi  = mag[NW-2:QW];
    ovf = DW'(hi) >= den;
  end

  always_comb begin
    logic [DW:0] t;
    logic        ge;
    for (int k = 0; k < QW; k++) begin
      t  = {rem_r[k], sh_r[k][QW-1]};
      ge = t >= {1'b0, den_r[k]};
      rem_nxt[k] = ge ? DW'(t - {1'b0, den_r[k]}) : t[DW-1:0];
      sh_nxt[k]  = {sh_r[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ovf ? '0 : DW'(hi);
      sh_r[0]  <= mag[QW-1:0];
      den_r[0] <= den;
      neg_r[0] <= num[NW-1];
      ovf_r[0] <= ovf;
      for (int k = 0; k < QW; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        sh_r[k+1]  <= sh_nxt[k];
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  always_comb begin
    logic [QW:0] q;
    q   = ovf_r[QW] ? {1'b0, {QW{1'b1}}} : {1'b0, sh_r[QW]};
    quo = neg_r[QW] ? ~q : q;
  end

endmodule
`default_nettype wire
